// ===== sv/shc_pkg.sv =====
package shc_pkg;

   localparam int DETAIL_BYTES_DEF   = 32;
   localparam int MAX_SEED_BYTES_DEF = 32;

   localparam int STATUS_W = 3;
   localparam int SEED_W   = 6;
   localparam int CSR_IDX_W = 2;

   // verdict codes
   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SEQ    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DIGEST = 3'd3;
   localparam logic [STATUS_W-1:0] ST_HEAD   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BUSY   = 3'd5;

   // operations
   localparam logic [1:0] OP_BEGIN  = 2'd0;
   localparam logic [1:0] OP_RECORD = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_BYTES    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_DIGESTS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_HEAD    = 2'd2;

   localparam int LABEL_LEN = 20;
   localparam logic [7:0] LABEL [LABEL_LEN] = '{
      8'h6F, 8'h72, 8'h74, 8'h68, 8'h72, 8'h75, 8'h73, 8'h2F, 8'h65, 8'h76,
      8'h69, 8'h64, 8'h65, 8'h6E, 8'h63, 8'h65, 8'h2F, 8'h76, 8'h31, 8'h00
   };

   localparam logic [31:0] KROUND [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] HINIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic capture;
      logic load_msg;
      logic load_blk;
      logic do_round;
      logic add_state;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_hash;
      logic last_round;
      logic more_blk;
   } stat_type;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

// ===== sv/shc_ctrl.sv =====
module shc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  shc_pkg::stat_type stat,
   output shc_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_BLK    = 3'd3;
   localparam logic [2:0] S_ROUND  = 3'd4;
   localparam logic [2:0] S_ADD    = 3'd5;
   localparam logic [2:0] S_COMMIT = 3'd6;
   localparam logic [2:0] S_RESP   = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = stat.need_hash ? S_LOAD : S_COMMIT;
         end
         S_LOAD: begin
            cmd.load_msg = 1'b1;
            state_in     = S_BLK;
         end
         S_BLK: begin
            cmd.load_blk = 1'b1;
            state_in     = S_ROUND;
         end
         S_ROUND: begin
            cmd.do_round = 1'b1;
            if (stat.last_round) state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add_state = 1'b1;
            state_in      = stat.more_blk ? S_BLK : S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== sv/shc_datapath.sv =====
module shc_datapath #(
   parameter int DETAIL_BYTES   = shc_pkg::DETAIL_BYTES_DEF,
   parameter int MAX_SEED_BYTES = shc_pkg::MAX_SEED_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [shc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [shc_pkg::SEED_W-1:0]      csr_wdata,
   input  logic [1:0]                      req_op,
   input  logic [31:0]                     req_seq,
   input  logic [31:0]                     req_time_ms,
   input  logic [7:0]                      req_kind,
   input  logic [63:0]                     req_data_0,
   input  logic [63:0]                     req_data_1,
   input  logic [63:0]                     req_data_2,
   input  logic [63:0]                     req_data_3,
   input  logic [63:0]                     req_expect_0,
   input  logic [63:0]                     req_expect_1,
   input  logic [63:0]                     req_expect_2,
   input  logic [63:0]                     req_expect_3,
   input  shc_pkg::cmd_type                cmd,
   output shc_pkg::stat_type               stat,
   output logic [shc_pkg::STATUS_W-1:0]    rsp_status,
   output logic [31:0]                     rsp_failed_at,
   output logic [31:0]                     rsp_records_ok,
   output logic [63:0]                     rsp_head_0,
   output logic [63:0]                     rsp_head_1,
   output logic [63:0]                     rsp_head_2,
   output logic [63:0]                     rsp_head_3
);

   localparam int REC_LEN = 41 + DETAIL_BYTES;
   localparam int SEED_CAP = (MAX_SEED_BYTES < 32) ? MAX_SEED_BYTES : 32;

   // configuration
   logic [shc_pkg::SEED_W-1:0] seed_bytes_ff;
   logic                       check_digests_ff;
   logic                       check_head_ff;

   // captured word
   logic [1:0]   op_ff;
   logic [31:0]  seq_ff;
   logic [31:0]  tms_ff;
   logic [7:0]   kind_ff;
   logic [255:0] data_ff;
   logic [255:0] expect_ff;

   // chain state
   logic [255:0]                  head_ff, head_in;
   logic [31:0]                   count_ff, count_in;
   logic [shc_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [31:0]                   fail_ff, fail_in;
   logic [31:0]                   verified_ff, verified_in;

   // hash engine
   logic [1023:0] msg_ff, msg_in;
   logic          two_blk_ff, two_blk_in;
   logic          blk_ff;
   logic [5:0]    round_ff;
   logic [31:0]   st_ff [8];
   logic [31:0]   v_ff [8];
   logic [31:0]   w_ff [16];

   // result register
   logic [shc_pkg::STATUS_W-1:0]  out_status_ff, out_status_in;
   logic [31:0]                   out_fail_ff, out_fail_in;
   logic [31:0]                   out_ok_ff;
   logic [255:0]                  out_head_ff;

   logic seq_broken;
   assign seq_broken = check_digests_ff && (seq_ff != count_ff);

   assign stat.need_hash = (op_ff == shc_pkg::OP_BEGIN) ||
                           ((op_ff == shc_pkg::OP_RECORD) &&
                            (status_ff == shc_pkg::ST_BUSY) && !seq_broken);
   assign stat.last_round = (round_ff == 6'd63);
   assign stat.more_blk   = two_blk_ff && !blk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_bytes_ff    <= '0;
         check_digests_ff <= 1'b1;
         check_head_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            shc_pkg::CSR_SEED_BYTES:    seed_bytes_ff    <= csr_wdata;
            shc_pkg::CSR_CHECK_DIGESTS: check_digests_ff <= csr_wdata[0];
            shc_pkg::CSR_CHECK_HEAD:    check_head_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_op;
         seq_ff    <= req_seq;
         tms_ff    <= req_time_ms;
         kind_ff   <= req_kind;
         data_ff   <= {req_data_3, req_data_2, req_data_1, req_data_0};
         expect_ff <= {req_expect_3, req_expect_2, req_expect_1, req_expect_0};
      end
   end

   // padded message, byte j at msg[1023-8j -: 8]
   always_comb begin
      logic [6:0]  len;
      logic [6:0]  jj;
      logic [6:0]  last;
      logic [15:0] bits;
      logic [7:0]  cb;
      logic [7:0]  bv;
      logic [6:0]  sl;
      sl = (seed_bytes_ff > 6'(SEED_CAP)) ? 7'(SEED_CAP) : {1'b0, seed_bytes_ff};
      if (op_ff == shc_pkg::OP_BEGIN) len = 7'(shc_pkg::LABEL_LEN) + sl;
      else                            len = 7'(REC_LEN);
      two_blk_in = (len > 7'd55);
      last = two_blk_in ? 7'd127 : 7'd63;
      bits = {6'b0, len, 3'b000};
      msg_in = '0;
      for (int j = 0; j < 128; j++) begin
         jj = 7'(j);
         if (op_ff == shc_pkg::OP_BEGIN) begin
            if (j < shc_pkg::LABEL_LEN) cb = shc_pkg::LABEL[j % shc_pkg::LABEL_LEN];
            else                        cb = data_ff[8*((j + 12) % 32) +: 8];
         end else begin
            if (j < 32)       cb = head_ff[8*(j % 32) +: 8];
            else if (j < 36)  cb = seq_ff[8*(j % 4) +: 8];
            else if (j < 40)  cb = tms_ff[8*(j % 4) +: 8];
            else if (j == 40) cb = kind_ff;
            else              cb = data_ff[8*((j + 23) % 32) +: 8];
         end
         if (jj < len)                bv = cb;
         else if (jj == len)          bv = 8'h80;
         else if (jj == last)         bv = bits[7:0];
         else if (jj == last - 7'd1)  bv = bits[15:8];
         else                         bv = 8'h00;
         msg_in[1023-8*j -: 8] = bv;
      end
   end

   // one round per cycle
   logic [31:0] t1, t2, w_new;
   always_comb begin
      t1 = v_ff[7] + shc_pkg::big_sigma1(v_ff[4]) +
           ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) +
           shc_pkg::KROUND[round_ff] + w_ff[0];
      t2 = shc_pkg::big_sigma0(v_ff[0]) +
           ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      w_new = w_ff[0] + shc_pkg::small_sigma0(w_ff[1]) + w_ff[9] +
              shc_pkg::small_sigma1(w_ff[14]);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_msg) begin
         msg_ff     <= msg_in;
         two_blk_ff <= two_blk_in;
         blk_ff     <= 1'b0;
         for (int i = 0; i < 8; i++) st_ff[i] <= shc_pkg::HINIT[i];
      end
      if (cmd.load_blk) begin
         round_ff <= '0;
         for (int i = 0; i < 8; i++) v_ff[i] <= st_ff[i];
         for (int i = 0; i < 16; i++)
            w_ff[i] <= blk_ff ? msg_ff[511-32*i -: 32] : msg_ff[1023-32*i -: 32];
      end
      if (cmd.do_round) begin
         round_ff <= round_ff + 6'd1;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
      end
      if (cmd.add_state) begin
         blk_ff <= 1'b1;
         for (int i = 0; i < 8; i++) st_ff[i] <= st_ff[i] + v_ff[i];
      end
   end

   // digest in low-byte-first word order
   logic [255:0] digest;
   always_comb begin
      for (int i = 0; i < 32; i++)
         digest[8*i +: 8] = st_ff[i/4][31-8*(i%4) -: 8];
   end

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      fail_in       = fail_ff;
      verified_in   = verified_ff;
      out_status_in = status_ff;
      out_fail_in   = fail_ff;
      case (op_ff)
         shc_pkg::OP_BEGIN: begin
            head_in     = digest;
            count_in    = '0;
            status_in   = shc_pkg::ST_BUSY;
            fail_in     = '0;
            verified_in = '0;
         end
         shc_pkg::OP_RECORD: begin
            if (status_ff == shc_pkg::ST_BUSY) begin
               if (seq_broken) begin
                  status_in = shc_pkg::ST_SEQ;
                  fail_in   = seq_ff;
               end else begin
                  head_in  = digest;
                  count_in = count_ff + 32'd1;
                  if (check_digests_ff && (digest != expect_ff)) begin
                     status_in = shc_pkg::ST_DIGEST;
                     fail_in   = seq_ff;
                  end else begin
                     verified_in = verified_ff + 32'd1;
                  end
               end
            end
         end
         shc_pkg::OP_FINISH: begin
            if (status_ff != shc_pkg::ST_BUSY) begin
               out_status_in = status_ff;
            end else if (count_ff == '0) begin
               out_status_in = shc_pkg::ST_EMPTY;
               out_fail_in   = '0;
            end else if (check_head_ff && (head_ff != expect_ff)) begin
               out_status_in = shc_pkg::ST_HEAD;
               out_fail_in   = count_ff;
            end else begin
               out_status_in = shc_pkg::ST_OK;
               out_fail_in   = '0;
            end
         end
         default: ;
      endcase
      if (op_ff != shc_pkg::OP_FINISH) begin
         out_status_in = status_in;
         out_fail_in   = fail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         count_ff    <= '0;
         status_ff   <= shc_pkg::ST_BUSY;
         fail_ff     <= '0;
         verified_ff <= '0;
      end else if (cmd.commit) begin
         head_ff     <= head_in;
         count_ff    <= count_in;
         status_ff   <= status_in;
         fail_ff     <= fail_in;
         verified_ff <= verified_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_status_ff <= out_status_in;
         out_fail_ff   <= out_fail_in;
         out_ok_ff     <= verified_in;
         out_head_ff   <= head_in;
      end
   end

   assign rsp_status     = out_status_ff;
   assign rsp_failed_at  = out_fail_ff;
   assign rsp_records_ok = out_ok_ff;
   assign rsp_head_0     = out_head_ff[63:0];
   assign rsp_head_1     = out_head_ff[127:64];
   assign rsp_head_2     = out_head_ff[191:128];
   assign rsp_head_3     = out_head_ff[255:192];

endmodule

// ===== sv/sha256_hash_chain_verifier.sv =====
// channel   direction  handshake            payload
// req_      in         req_valid/req_ready  op, seq, time_ms, kind, data_0..3, expect_0..3
// rsp_      out        rsp_valid/rsp_ready  status, failed_at, records_ok, head_0..3
// csr_      in         csr_we               csr_index, csr_wdata
//
// one word at a time; sha-256 runs one round per cycle on a single compression unit
// record word: two blocks are hashed (one if the record fits in one block), then commit
// begin word: one block; finish, refused record and unused op: no hash, straight to commit
// next word accepted the cycle after the response is taken
// reset is synchronous: verdict in progress, zero head and counts, registers to defaults
module sha256_hash_chain_verifier #(
   parameter int DETAIL_BYTES   = shc_pkg::DETAIL_BYTES_DEF,
   parameter int MAX_SEED_BYTES = shc_pkg::MAX_SEED_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_we,
   input  logic [shc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [shc_pkg::SEED_W-1:0]      csr_wdata,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_op,
   input  logic [31:0]                     req_seq,
   input  logic [31:0]                     req_time_ms,
   input  logic [7:0]                      req_kind,
   input  logic [63:0]                     req_data_0,
   input  logic [63:0]                     req_data_1,
   input  logic [63:0]                     req_data_2,
   input  logic [63:0]                     req_data_3,
   input  logic [63:0]                     req_expect_0,
   input  logic [63:0]                     req_expect_1,
   input  logic [63:0]                     req_expect_2,
   input  logic [63:0]                     req_expect_3,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [shc_pkg::STATUS_W-1:0]    rsp_status,
   output logic [31:0]                     rsp_failed_at,
   output logic [31:0]                     rsp_records_ok,
   output logic [63:0]                     rsp_head_0,
   output logic [63:0]                     rsp_head_1,
   output logic [63:0]                     rsp_head_2,
   output logic [63:0]                     rsp_head_3
);

   // controller to datapath commands, datapath to controller status
   shc_pkg::cmd_type  cmd;
   shc_pkg::stat_type stat;

   // sequencer: capture, decide, pad, per block load + 64 rounds + add, commit, respond
   shc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // message builder, compression unit, chain state and verdict logic
   shc_datapath #(
      .DETAIL_BYTES   (DETAIL_BYTES),
      .MAX_SEED_BYTES (MAX_SEED_BYTES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_op         (req_op),
      .req_seq        (req_seq),
      .req_time_ms    (req_time_ms),
      .req_kind       (req_kind),
      .req_data_0     (req_data_0),
      .req_data_1     (req_data_1),
      .req_data_2     (req_data_2),
      .req_data_3     (req_data_3),
      .req_expect_0   (req_expect_0),
      .req_expect_1   (req_expect_1),
      .req_expect_2   (req_expect_2),
      .req_expect_3   (req_expect_3),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_status     (rsp_status),
      .rsp_failed_at  (rsp_failed_at),
      .rsp_records_ok (rsp_records_ok),
      .rsp_head_0     (rsp_head_0),
      .rsp_head_1     (rsp_head_1),
      .rsp_head_2     (rsp_head_2),
      .rsp_head_3     (rsp_head_3)
   );

endmodule

// ===== sv/shc_checker.sv =====
module shc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [shc_pkg::STATUS_W-1:0] rsp_status,
   input logic [31:0]                  rsp_failed_at
);

   // a held response keeps its verdict
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_failed_at))
      else $error("response changed while stalled");

   // one word in flight: no request taken while a response waits
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while response pending");

   // a response never appears the cycle after a request is taken
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("response too early");

   // ok, empty and in progress carry no failure position
   a_ok_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == shc_pkg::ST_OK || rsp_status == shc_pkg::ST_BUSY
                    || rsp_status == shc_pkg::ST_EMPTY) |-> rsp_failed_at == 32'd0)
      else $error("failure position on a clean verdict");

endmodule

bind sha256_hash_chain_verifier shc_checker u_shc_checker (.*);
